/* sv/bda_pkg.sv */
package bda_pkg;

  localparam int OUT_WIDTH_W  = 11;
  localparam int OUT_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;
  localparam int ROW_W        = 12;
  localparam int DIM_W        = 14;
  localparam int SUM_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int MAX_HEIGHT   = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT = 1'b1;

  localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST  = 11'd640;
  localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [CHAN_W-1:0] sample_red;
    logic [CHAN_W-1:0] sample_green;
    logic [CHAN_W-1:0] sample_blue;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  emit;
    logic  frame_end;
    sums_t sums;
  } issue_t;

endpackage

/* sv/bda_ctrl.sv */
module bda_ctrl #(
  parameter int FACTOR        = 2,
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int COL_W         = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  bda_pkg::sample_t                 in_data,
  input  logic                             cfg_we,
  input  logic [bda_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bda_pkg::issue_t                  issue,
  output logic [COL_W-1:0]                 issue_col
);

  localparam int SUB_W = $clog2(FACTOR + 1);

  logic [bda_pkg::OUT_WIDTH_W-1:0]  out_width_r;
  logic [bda_pkg::OUT_HEIGHT_W-1:0] out_height_r;
  logic [SUB_W-1:0]                 sub_col_r, sub_col_nxt;
  logic [SUB_W-1:0]                 sub_row_r, sub_row_nxt;
  logic [COL_W-1:0]                 out_col_r, out_col_nxt;
  logic [bda_pkg::ROW_W-1:0]        out_row_r, out_row_nxt;
  bda_pkg::sums_t                   rp_r, rp_nxt, rp_sum;

  logic [bda_pkg::DIM_W-1:0] w_raw, h_raw, w_eff, h_eff;
  logic [bda_pkg::DIM_W-1:0] col_ext, colc_ext, col_inc;
  logic [bda_pkg::DIM_W-1:0] row_ext, rowc_ext, row_inc;
  logic [SUB_W-1:0]          sub_col_inc, sub_row_inc;
  logic                      block_done, col_wrap, row_wrap;

  always_comb begin
    w_raw = bda_pkg::DIM_W'(out_width_r);
    h_raw = bda_pkg::DIM_W'(out_height_r);
    priority if (w_raw == '0) begin
      w_eff = bda_pkg::DIM_W'(1);
    end else if (w_raw > bda_pkg::DIM_W'(MAX_OUT_WIDTH)) begin
      w_eff = bda_pkg::DIM_W'(MAX_OUT_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    priority if (h_raw == '0) begin
      h_eff = bda_pkg::DIM_W'(1);
    end else if (h_raw > bda_pkg::DIM_W'(bda_pkg::MAX_HEIGHT)) begin
      h_eff = bda_pkg::DIM_W'(bda_pkg::MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  always_comb begin
    rp_sum.red   = rp_r.red   + bda_pkg::SUM_W'(in_data.sample_red);
    rp_sum.green = rp_r.green + bda_pkg::SUM_W'(in_data.sample_green);
    rp_sum.blue  = rp_r.blue  + bda_pkg::SUM_W'(in_data.sample_blue);

    sub_col_inc = sub_col_r + SUB_W'(1);
    sub_row_inc = sub_row_r + SUB_W'(1);
    block_done  = (sub_col_inc >= SUB_W'(FACTOR));

    col_ext  = bda_pkg::DIM_W'(out_col_r);
    colc_ext = (col_ext >= w_eff) ? (w_eff - bda_pkg::DIM_W'(1)) : col_ext;
    col_inc  = colc_ext + bda_pkg::DIM_W'(1);
    col_wrap = (col_inc >= w_eff);

    row_ext  = bda_pkg::DIM_W'(out_row_r);
    rowc_ext = (row_ext >= h_eff) ? (h_eff - bda_pkg::DIM_W'(1)) : row_ext;
    row_inc  = rowc_ext + bda_pkg::DIM_W'(1);
    row_wrap = (row_inc >= h_eff);

    sub_col_nxt = sub_col_r;
    sub_row_nxt = sub_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    rp_nxt      = rp_r;
    if (accept) begin
      if (!block_done) begin
        sub_col_nxt = sub_col_inc;
        rp_nxt      = rp_sum;
      end else begin
        sub_col_nxt = '0;
        rp_nxt      = '0;
        out_row_nxt = rowc_ext[bda_pkg::ROW_W-1:0];
        if (col_wrap) begin
          out_col_nxt = '0;
          if (sub_row_inc >= SUB_W'(FACTOR)) begin
            sub_row_nxt = '0;
            out_row_nxt = row_wrap ? '0 : row_inc[bda_pkg::ROW_W-1:0];
          end else begin
            sub_row_nxt = sub_row_inc;
          end
        end else begin
          out_col_nxt = col_inc[COL_W-1:0];
        end
      end
    end

    issue.valid     = accept && block_done;
    issue.first     = (sub_row_r == '0);
    issue.emit      = (sub_row_inc >= SUB_W'(FACTOR));
    issue.frame_end = col_wrap && row_wrap;
    issue.sums      = rp_sum;
    issue_col       = colc_ext[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= bda_pkg::OUT_WIDTH_RST;
      out_height_r <= bda_pkg::OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bda_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_data[bda_pkg::OUT_WIDTH_W-1:0];
        bda_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_data[bda_pkg::OUT_HEIGHT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      sub_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      rp_r      <= '0;
    end else begin
      sub_col_r <= sub_col_nxt;
      sub_row_r <= sub_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      rp_r      <= rp_nxt;
    end
  end

endmodule

/* sv/bda_accum.sv */
module bda_accum #(
  parameter int FACTOR        = 2,
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int COL_W         = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  bda_pkg::issue_t  issue,
  input  logic [COL_W-1:0] issue_col,
  output logic             out_valid,
  output bda_pkg::pixel_t  out_data
);

  localparam int AREA     = FACTOR * FACTOR;
  localparam int AREA_LOG = $clog2(AREA);
  localparam int SHIFT    = bda_pkg::SUM_W + AREA_LOG;
  localparam int RECIP_W  = bda_pkg::SUM_W + 2;
  localparam int PROD_W   = bda_pkg::SUM_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(AREA) - 64'd1) / 64'(AREA);

  bda_pkg::sums_t   mem [MAX_OUT_WIDTH];

  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_r;
  logic             s1_emit_r;
  logic             s1_fe_r;
  bda_pkg::sums_t   s1_rp_r;
  bda_pkg::sums_t   mem_rd_r;
  logic             fwd_r;
  bda_pkg::sums_t   fwd_data_r;
  logic             out_valid_r;
  bda_pkg::pixel_t  out_data_r;

  bda_pkg::sums_t   rd_eff, new_sum;
  bda_pkg::pixel_t  pix;

  // The rounded-up reciprocal gives the exact truncated quotient for every 16-bit sum.
  function automatic logic [bda_pkg::CHAN_W-1:0] area_div(input logic [bda_pkg::SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(RECIP);
    return prod[SHIFT +: bda_pkg::CHAN_W];
  endfunction

  always_comb begin
    rd_eff = fwd_r ? fwd_data_r : mem_rd_r;
    if (s1_first_r) begin
      new_sum = s1_rp_r;
    end else begin
      new_sum.red   = rd_eff.red   + s1_rp_r.red;
      new_sum.green = rd_eff.green + s1_rp_r.green;
      new_sum.blue  = rd_eff.blue  + s1_rp_r.blue;
    end
    pix.pixel_red   = area_div(new_sum.red);
    pix.pixel_green = area_div(new_sum.green);
    pix.pixel_blue  = area_div(new_sum.blue);
    pix.frame_end   = s1_fe_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_valid_r) begin
        mem[s1_col_r] <= new_sum;
      end
      if (issue.valid) begin
        mem_rd_r <= mem[issue_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col_r   <= issue_col;
      s1_first_r <= issue.first;
      s1_emit_r  <= issue.emit;
      s1_fe_r    <= issue.frame_end;
      s1_rp_r    <= issue.sums;
      fwd_r      <= s1_valid_r && (s1_col_r == issue_col);
      fwd_data_r <= new_sum;
      out_data_r <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= issue.valid;
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/box_downsample_average.sv */
// The last sample transaction of a block is registered in the s1 stage, then in the output register.
// Throughput: one sample per cycle; the column-sum memory is read and written once per block row
// segment, with a bypass for back-to-back updates of the same column.
// The whole pipeline holds while an output transaction is stalled.
// Reset is synchronous and active low; it restores the default size and clears all counters.
module box_downsample_average #(
  parameter int FACTOR        = 2,
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bda_pkg::sample_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bda_pkg::pixel_t                  out_data,
  input  logic                             cfg_we,
  input  logic [bda_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  logic             advance;
  logic             accept;
  bda_pkg::issue_t  issue;
  logic [COL_W-1:0] issue_col;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  bda_ctrl #(
    .FACTOR        (FACTOR),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .COL_W         (COL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .issue     (issue),
    .issue_col (issue_col)
  );

  bda_accum #(
    .FACTOR        (FACTOR),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .COL_W         (COL_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .issue     (issue),
    .issue_col (issue_col),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/bda_checker.sv */
module bda_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input bda_pkg::pixel_t  out_data
);

  // The input side stalls exactly when a finished pixel is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the held output transaction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A new pixel always comes from an earlier input transaction, through the s1 and output registers.
  a_pixel_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output pixel without a matching input transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

endmodule

bind box_downsample_average bda_checker u_bda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int FACTOR = 2;
  localparam int MAX_W = 1024;
  localparam int unsigned AREA = FACTOR * FACTOR;
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int NUM_PHASES = 24;
  localparam int NUM_ROWS = 18;

  typedef enum logic [1:0] {ROW_SAMPLES, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [15:0]                    count;
    logic [bda_pkg::CFG_DATA_W-1:0] value;
    bda_pkg::sample_t               smp;
    logic                           listed;
    bda_pkg::pixel_t                px;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  bda_pkg::sample_t                in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  bda_pkg::pixel_t                 out_data;
  logic                            cfg_we = 1'b0;
  logic [bda_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bda_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned pixels_checked = 0;
  int unsigned frame_ends_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned frame_ends_expected = 0;
  int unsigned reg_writes = 0;

  logic [bda_pkg::OUT_WIDTH_W-1:0]  cfg_width = bda_pkg::OUT_WIDTH_RST;
  logic [bda_pkg::OUT_HEIGHT_W-1:0] cfg_height = bda_pkg::OUT_HEIGHT_RST;
  int unsigned      sub_col = 0;
  int unsigned      sub_row = 0;
  int unsigned      out_col = 0;
  int unsigned      out_row = 0;
  bda_pkg::sums_t   row_sum = '0;
  bda_pkg::sums_t   col_sum [MAX_W];
  bit               col_written [MAX_W];
  bda_pkg::pixel_t  expected_pixels [$];
  bda_pkg::pixel_t  head_pixel;

  // Rows with a listed pixel carry the expected transaction for the sample that completes a block.
  plan_row_t directed_plan [NUM_ROWS] = '{
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'd200, 8'd100, 8'd50}, 1'b0, '0},
    '{ROW_WIDTH, 16'd0, 13'd1, '0, 1'b0, '0},
    '{ROW_HEIGHT, 16'd0, 13'd1, '0, 1'b0, '0},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'd200, 8'd100, 8'd50}, 1'b1,
      '{8'd200, 8'd100, 8'd50, 1'b1}},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'd16, 8'd32, 8'd64}, 1'b0, '0},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{ROW_SAMPLES, 16'd1, 13'd0, '{8'd255, 8'd1, 8'd170}, 1'b0, '0},
    '{ROW_SAMPLES, 16'd1, 13'd0, '{8'd255, 8'd1, 8'd85}, 1'b0, '0},
    '{ROW_SAMPLES, 16'd1, 13'd0, '{8'd255, 8'd1, 8'd170}, 1'b0, '0},
    '{ROW_SAMPLES, 16'd1, 13'd0, '{8'd254, 8'd0, 8'd85}, 1'b1,
      '{8'd254, 8'd0, 8'd127, 1'b1}},
    '{ROW_WIDTH, 16'd0, 13'd0, '0, 1'b0, '0},
    '{ROW_HEIGHT, 16'd0, 13'd0, '0, 1'b0, '0},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'h55, 8'hAA, 8'h0F}, 1'b1,
      '{8'h55, 8'hAA, 8'h0F, 1'b1}},
    '{ROW_SAMPLES, 16'd4, 13'd0, '{8'hAA, 8'h55, 8'hF0}, 1'b1,
      '{8'hAA, 8'h55, 8'hF0, 1'b1}},
    '{ROW_WIDTH, 16'd0, 13'd2, '0, 1'b0, '0},
    '{ROW_HEIGHT, 16'd0, 13'd8191, '0, 1'b0, '0},
    '{ROW_SAMPLES, 16'd8, 13'd0, '{8'h12, 8'h34, 8'h56}, 1'b0, '0}
  };

  box_downsample_average #(
    .FACTOR(FACTOR),
    .MAX_OUT_WIDTH(MAX_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic log_mismatch(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  function automatic int unsigned eff_width(input logic [bda_pkg::OUT_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(input logic [bda_pkg::OUT_HEIGHT_W-1:0] h);
    if (h == 0) return 1;
    if (h > bda_pkg::MAX_HEIGHT) return bda_pkg::MAX_HEIGHT;
    return 32'(h);
  endfunction

  function automatic bit predict_pixel(input bda_pkg::sample_t smp, output bda_pkg::pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    bit fired;
    w = eff_width(cfg_width);
    h = eff_height(cfg_height);
    px = '0;
    fired = 1'b0;
    row_sum.red = row_sum.red + 16'(smp.sample_red);
    row_sum.green = row_sum.green + 16'(smp.sample_green);
    row_sum.blue = row_sum.blue + 16'(smp.sample_blue);
    sub_col++;
    if (sub_col < FACTOR) return 1'b0;
    sub_col = 0;
    if (out_col >= w) out_col = w - 1;
    col = out_col;
    if (sub_row == 0) begin
      col_sum[col] = row_sum;
    end else begin
      col_sum[col].red = col_sum[col].red + row_sum.red;
      col_sum[col].green = col_sum[col].green + row_sum.green;
      col_sum[col].blue = col_sum[col].blue + row_sum.blue;
    end
    col_written[col] = 1'b1;
    row_sum = '0;
    if (out_row >= h) out_row = h - 1;
    if (sub_row + 1 >= FACTOR) begin
      px.pixel_red = 8'(col_sum[col].red / AREA);
      px.pixel_green = 8'(col_sum[col].green / AREA);
      px.pixel_blue = 8'(col_sum[col].blue / AREA);
      px.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
      fired = 1'b1;
    end
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      sub_row++;
      if (sub_row >= FACTOR) begin
        sub_row = 0;
        out_row++;
        if (out_row >= h) out_row = 0;
      end
    end
    return fired;
  endfunction

  // A wider image may not start in the second sample row of a block unless every
  // column it covers already holds a sum.
  function automatic bit width_is_safe(input logic [bda_pkg::OUT_WIDTH_W-1:0] w);
    int unsigned n;
    n = eff_width(w);
    if (sub_row == 0) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!col_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [bda_pkg::CHAN_W-1:0] random_channel();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic bda_pkg::sample_t random_sample();
    bda_pkg::sample_t smp;
    smp.sample_red = random_channel();
    smp.sample_green = random_channel();
    smp.sample_blue = random_channel();
    return smp;
  endfunction

  function automatic logic [bda_pkg::CFG_DATA_W-1:0] pick_width();
    int unsigned r;
    logic [bda_pkg::CFG_DATA_W-1:0] w;
    r = $urandom_range(99);
    if (r < 5) w = '0;
    else if (r < 65) w = 13'($urandom_range(4, 1));
    else if (r < 92) w = 13'($urandom_range(12, 5));
    else w = 13'($urandom_range(40, 13));
    if ($urandom_range(3) == 0) begin
      w[bda_pkg::CFG_DATA_W-1:bda_pkg::OUT_WIDTH_W] = 2'($urandom_range(3));
    end
    return w;
  endfunction

  function automatic logic [bda_pkg::CFG_DATA_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 85) return 13'($urandom_range(4, 1));
    if (r < 95) return 13'($urandom_range(9, 5));
    return 13'($urandom_range(8191, 4097));
  endfunction

  function automatic void set_idle_mode(input int mode);
    unique case (mode)
      0: begin
        send_idle_pct = 15;
        recv_idle_pct = 88;
      end
      1: begin
        send_idle_pct = 88;
        recv_idle_pct = 15;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d pixels still expected.", expected_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (out_data.frame_end === 1'b1) frame_ends_seen++;
      if (expected_pixels.size() == 0) begin
        log_mismatch($sformatf("Unexpected pixel r=%0d g=%0d b=%0d end=%0b",
                               out_data.pixel_red, out_data.pixel_green,
                               out_data.pixel_blue, out_data.frame_end));
      end else begin
        head_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.pixel_red !== head_pixel.pixel_red ||
            out_data.pixel_green !== head_pixel.pixel_green ||
            out_data.pixel_blue !== head_pixel.pixel_blue ||
            out_data.frame_end !== head_pixel.frame_end) begin
          log_mismatch($sformatf(
            "Pixel %0d: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
            pixels_checked, head_pixel.pixel_red, head_pixel.pixel_green,
            head_pixel.pixel_blue, head_pixel.frame_end, out_data.pixel_red,
            out_data.pixel_green, out_data.pixel_blue, out_data.frame_end));
        end
      end
    end
  end

  task automatic send_sample(input bda_pkg::sample_t smp, input logic listed,
                             input bda_pkg::pixel_t listed_px);
    bda_pkg::pixel_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= smp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    samples_sent++;
    if (predict_pixel(smp, px)) begin
      if (listed) px = listed_px;
      expected_pixels.push_back(px);
      if (px.frame_end) frame_ends_expected++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bda_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bda_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bda_pkg::REG_OUT_WIDTH) cfg_width = data[bda_pkg::OUT_WIDTH_W-1:0];
    else cfg_height = data[bda_pkg::OUT_HEIGHT_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic resize(input logic [bda_pkg::CFG_DATA_W-1:0] wdata,
                        input logic [bda_pkg::CFG_DATA_W-1:0] hdata);
    while (!width_is_safe(wdata[bda_pkg::OUT_WIDTH_W-1:0])) begin
      send_sample(random_sample(), 1'b0, '0);
    end
    drain();
    write_reg(bda_pkg::REG_OUT_WIDTH, wdata);
    write_reg(bda_pkg::REG_OUT_HEIGHT, hdata);
  endtask

  initial begin
    plan_row_t row;
    int unsigned items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_idle_mode(0);
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_plan[i];
      unique case (row.kind)
        ROW_WIDTH: begin
          drain();
          write_reg(bda_pkg::REG_OUT_WIDTH, row.value);
        end
        ROW_HEIGHT: begin
          drain();
          write_reg(bda_pkg::REG_OUT_HEIGHT, row.value);
        end
        default: begin
          repeat (row.count) send_sample(row.smp, row.listed, row.px);
        end
      endcase
    end
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_idle_mode(phase / 8);
      if (phase == 3) begin
        // The upper data bits fall outside the width register, leaving exactly 1024.
        resize(13'h1C00, 13'd1);
      end else if (phase == 12) begin
        resize(13'($urandom_range(2047, 1025)), 13'd1);
      end else if (phase == 20) begin
        resize(13'd1, 13'd4096);
      end else begin
        resize(pick_width(), pick_height());
      end
      items = $urandom_range(36, 14);
      repeat (items) send_sample(random_sample(), 1'b0, '0);
    end
    drain();
    $display("Sent %0d samples across %0d register writes; checked %0d pixels, %0d of %0d frame ends.",
             samples_sent, reg_writes, pixels_checked, frame_ends_seen, frame_ends_expected);
    $display("Sizes ranged from one pixel up to 1024 columns and 4096 rows, with %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* box_downsample_average.f */
sv/bda_pkg.sv
sv/bda_ctrl.sv
sv/bda_accum.sv
sv/box_downsample_average.sv
sv/bda_checker.sv
test/testbench.sv
